// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Clocked assertion shorthands; each expects clk and rst_n in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, checked out of reset
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/col_pkg.sv =====
// ----------------------------------------------------------------------------
// col_pkg
// Shared types and codes for the circle overlap resolver pipeline.
// ----------------------------------------------------------------------------
package col_pkg;

    localparam logic [1:0] ST_APART   = 2'd0;
    localparam logic [1:0] ST_CONTACT = 2'd1;
    localparam logic [1:0] ST_COIN    = 2'd2;
    localparam logic [1:0] ST_SAT     = 2'd3;

    typedef enum logic [1:0] {
        K_PASS,
        K_COIN,
        K_CAND,
        K_CONTACT
    } kind_t;

    // sideband that travels with each word through the arithmetic units
    typedef struct packed {
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] bx;
        logic signed [31:0] by;
        logic               xneg;
        logic               yneg;
        logic [30:0]        ux;
        logic [30:0]        uy;
        logic [30:0]        rsum;
        logic               afix;
        logic               bfix;
        kind_t              kind;
    } ctx_t;

    typedef struct packed {
        logic signed [31:0] nax;
        logic signed [31:0] nay;
        logic signed [31:0] nbx;
        logic signed [31:0] nby;
        logic signed [31:0] fax;
        logic signed [31:0] fay;
        logic signed [31:0] fbx;
        logic signed [31:0] fby;
        logic [1:0]         status;
    } res_t;

endpackage

// ===== rtl/core/col_sqrt.sv =====
// ----------------------------------------------------------------------------
// col_sqrt
// Pipelined integer square root, one root bit per stage, 32 stages.
// ----------------------------------------------------------------------------
module col_sqrt (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  logic [62:0]   rad,
    input  col_pkg::ctx_t cin,
    output logic          vout,
    output logic [31:0]   root,
    output col_pkg::ctx_t cout
);
    import col_pkg::*;

    localparam int NS = 32;

    logic [NS-1:0] vld_reg;
    logic [63:0]   rem_reg   [NS];
    logic [31:0]   root_reg  [NS];
    ctx_t          ctx_reg   [NS];
    logic [63:0]   rem_cur   [NS];
    logic [31:0]   root_cur  [NS];
    logic [63:0]   trial     [NS];
    logic [63:0]   rem_next  [NS];
    logic [31:0]   root_next [NS];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            rem_cur[k]  = (k == 0) ? {1'b0, rad} : rem_reg[k-1];
            root_cur[k] = (k == 0) ? 32'd0 : root_reg[k-1];
            // trial = (root << (b+1)) + (1 << 2b), b = NS-1-k
            trial[k] = ({32'd0, root_cur[k]} << (NS - k))
                     | (64'd1 << (2 * (NS - 1 - k)));
            if (rem_cur[k] >= trial[k])
            begin
                rem_next[k]  = rem_cur[k] - trial[k];
                root_next[k] = root_cur[k] | (32'd1 << (NS - 1 - k));
            end
            else
            begin
                rem_next[k]  = rem_cur[k];
                root_next[k] = root_cur[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
            for (int k = 1; k < NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rem_reg[k]  <= rem_next[k];
                root_reg[k] <= root_next[k];
                ctx_reg[k]  <= (k == 0) ? cin : ctx_reg[k-1];
            end
        end
    end

    assign vout = vld_reg[NS-1];
    assign root = root_reg[NS-1];
    assign cout = ctx_reg[NS-1];

endmodule

// ===== rtl/core/col_div.sv =====
// ----------------------------------------------------------------------------
// col_div
// Pipelined restoring divider, two numerators over one divisor,
// one quotient bit per stage, 31 stages.
// ----------------------------------------------------------------------------
module col_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          en,
    input  logic          vin,
    input  logic [61:0]   num_x,
    input  logic [61:0]   num_y,
    input  logic [32:0]   den,
    input  col_pkg::ctx_t cin,
    output logic          vout,
    output logic [30:0]   qx,
    output logic [30:0]   qy,
    output col_pkg::ctx_t cout
);
    import col_pkg::*;

    localparam int NS = 31;

    logic [NS-1:0] vld_reg;
    logic [61:0]   rx_reg  [NS];
    logic [61:0]   ry_reg  [NS];
    logic [30:0]   qx_reg  [NS];
    logic [30:0]   qy_reg  [NS];
    logic [32:0]   den_reg [NS];
    ctx_t          ctx_reg [NS];
    logic [61:0]   rx_cur  [NS];
    logic [61:0]   ry_cur  [NS];
    logic [30:0]   qx_cur  [NS];
    logic [30:0]   qy_cur  [NS];
    logic [32:0]   den_cur [NS];
    logic [63:0]   dsh     [NS];
    logic [61:0]   rx_next [NS];
    logic [61:0]   ry_next [NS];
    logic [30:0]   qx_next [NS];
    logic [30:0]   qy_next [NS];

    always_comb
    begin
        for (int k = 0; k < NS; k++)
        begin
            rx_cur[k]  = (k == 0) ? num_x : rx_reg[k-1];
            ry_cur[k]  = (k == 0) ? num_y : ry_reg[k-1];
            qx_cur[k]  = (k == 0) ? 31'd0 : qx_reg[k-1];
            qy_cur[k]  = (k == 0) ? 31'd0 : qy_reg[k-1];
            den_cur[k] = (k == 0) ? den : den_reg[k-1];
            dsh[k]     = {31'd0, den_cur[k]} << (NS - 1 - k);
            rx_next[k] = rx_cur[k];
            qx_next[k] = qx_cur[k];
            ry_next[k] = ry_cur[k];
            qy_next[k] = qy_cur[k];
            if ({2'b00, rx_cur[k]} >= dsh[k])
            begin
                rx_next[k] = rx_cur[k] - dsh[k][61:0];
                qx_next[k] = qx_cur[k] | (31'd1 << (NS - 1 - k));
            end
            if ({2'b00, ry_cur[k]} >= dsh[k])
            begin
                ry_next[k] = ry_cur[k] - dsh[k][61:0];
                qy_next[k] = qy_cur[k] | (31'd1 << (NS - 1 - k));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg[0] <= vin;
            for (int k = 1; k < NS; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NS; k++)
            begin
                rx_reg[k]  <= rx_next[k];
                ry_reg[k]  <= ry_next[k];
                qx_reg[k]  <= qx_next[k];
                qy_reg[k]  <= qy_next[k];
                den_reg[k] <= den_cur[k];
                ctx_reg[k] <= (k == 0) ? cin : ctx_reg[k-1];
            end
        end
    end

    assign vout = vld_reg[NS-1];
    assign qx   = qx_reg[NS-1];
    assign qy   = qy_reg[NS-1];
    assign cout = ctx_reg[NS-1];

endmodule

// ===== rtl/core/circle_overlap_resolver_top.sv =====
// ----------------------------------------------------------------------------
// circle_overlap_resolver_top
// Resolves the overlap of two circles: pushes movable circles apart along
// the centre line and reports the matching force increments.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) takes one circle pair per word: centres,
//   radii and fixed flags. Output channel (out_valid/out_ready) returns one
//   word per pair: resolved centres, forces and status, in input order.
//   Throughput: one word per cycle while the output buffer is not full. A word
//   passes the input and squaring stages, the 32-stage square root, the scaling
//   stages, the 31-stage divider (one bit per stage) and the output stages.
//   Stall: the whole pipeline advances together; a two-entry output buffer
//   keeps in_ready high while one finished word waits, and holds the pipeline
//   only once that buffer is full. Nothing is lost or repeated.
//   Reset: all valid bits clear; the block comes up empty and ready.
// ----------------------------------------------------------------------------
module circle_overlap_resolver_top (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic [29:0]        a_radius,
    input  logic [29:0]        b_radius,
    input  logic               a_pinned,
    input  logic               b_pinned,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] new_a_x,
    output logic signed [31:0] new_a_y,
    output logic signed [31:0] new_b_x,
    output logic signed [31:0] new_b_y,
    output logic signed [31:0] force_a_x,
    output logic signed [31:0] force_a_y,
    output logic signed [31:0] force_b_x,
    output logic signed [31:0] force_b_y,
    output logic [1:0]         status
);
    import col_pkg::*;

    // {overflow, saturated value}
    function automatic logic [32:0] sat_sum(input logic [32:0] s);
        logic ovf;
        logic [31:0] v;
        ovf = (s[32] != s[31]);
        if (!ovf)
            v = s[31:0];
        else if (s[32])
            v = 32'h8000_0000;
        else
            v = 32'h7FFF_FFFF;
        return {ovf, v};
    endfunction

    logic en;

    // input stage
    logic [32:0] dx_w, dy_w, ux_w, uy_w;
    logic [30:0] rsum_w;
    logic        near_w;
    ctx_t        c0_next;
    logic        p0_vld_reg;
    ctx_t        p0_ctx_reg;

    // squares and sum
    logic        p1_vld_reg;
    ctx_t        p1_ctx_reg;
    logic [61:0] sqx_reg, sqy_reg;
    logic        p2_vld_reg;
    ctx_t        p2_ctx_reg;
    logic [62:0] rad_reg;

    // root
    logic        sq_vld;
    logic [31:0] sq_root;
    ctx_t        sq_ctx;

    // contact decision and scaling
    ctx_t        c3_next;
    logic [30:0] diff_next;
    logic [32:0] den_next;
    logic        p3_vld_reg;
    ctx_t        p3_ctx_reg;
    logic [30:0] diff_reg;
    logic [32:0] den_reg;
    logic        p4_vld_reg;
    ctx_t        p4_ctx_reg;
    logic [61:0] numx_reg, numy_reg;
    logic [32:0] den4_reg;

    // quotient and sign
    logic        dv_vld;
    logic [30:0] dv_qx, dv_qy;
    ctx_t        dv_ctx;
    logic        p5_vld_reg;
    ctx_t        p5_ctx_reg;
    logic signed [31:0] mx_reg, my_reg;

    // result and output buffer
    res_t        res_next;
    logic [32:0] sa_x, sa_y, sb_x, sb_y;
    logic        hit;
    logic        ov_vld_reg;
    res_t        ov_reg;
    logic        sk_full_reg;
    res_t        sk_reg;

    assign en       = !sk_full_reg;
    assign in_ready = en;

    always_comb
    begin
        dx_w   = {a_x[31], a_x} - {b_x[31], b_x};
        dy_w   = {a_y[31], a_y} - {b_y[31], b_y};
        ux_w   = dx_w[32] ? (33'd0 - dx_w) : dx_w;
        uy_w   = dy_w[32] ? (33'd0 - dy_w) : dy_w;
        rsum_w = {1'b0, a_radius} + {1'b0, b_radius};
        near_w = (ux_w <= {2'b00, rsum_w}) && (uy_w <= {2'b00, rsum_w});
        c0_next.ax   = a_x;
        c0_next.ay   = a_y;
        c0_next.bx   = b_x;
        c0_next.by   = b_y;
        c0_next.xneg = dx_w[32];
        c0_next.yneg = dy_w[32];
        c0_next.ux   = ux_w[30:0];
        c0_next.uy   = uy_w[30:0];
        c0_next.rsum = rsum_w;
        c0_next.afix = a_pinned;
        c0_next.bfix = b_pinned;
        if (a_pinned && b_pinned)
            c0_next.kind = K_PASS;
        else if (dx_w == 33'd0 && dy_w == 33'd0)
            c0_next.kind = K_COIN;
        else if (near_w)
            c0_next.kind = K_CAND;
        else
            c0_next.kind = K_PASS;
    end

    always_comb
    begin
        c3_next   = sq_ctx;
        diff_next = sq_ctx.rsum - sq_root[30:0];
        den_next  = (sq_ctx.afix || sq_ctx.bfix) ? {1'b0, sq_root} : {sq_root, 1'b0};
        if (sq_ctx.kind == K_CAND)
        begin
            if (sq_root <= {1'b0, sq_ctx.rsum})
                c3_next.kind = K_CONTACT;
            else
                c3_next.kind = K_PASS;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p0_vld_reg <= 1'b0;
            p1_vld_reg <= 1'b0;
            p2_vld_reg <= 1'b0;
            p3_vld_reg <= 1'b0;
            p4_vld_reg <= 1'b0;
            p5_vld_reg <= 1'b0;
        end
        else if (en)
        begin
            p0_vld_reg <= in_valid;
            p1_vld_reg <= p0_vld_reg;
            p2_vld_reg <= p1_vld_reg;
            p3_vld_reg <= sq_vld;
            p4_vld_reg <= p3_vld_reg;
            p5_vld_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p0_ctx_reg <= c0_next;
            p1_ctx_reg <= p0_ctx_reg;
            sqx_reg    <= p0_ctx_reg.ux * p0_ctx_reg.ux;
            sqy_reg    <= p0_ctx_reg.uy * p0_ctx_reg.uy;
            p2_ctx_reg <= p1_ctx_reg;
            rad_reg    <= {1'b0, sqx_reg} + {1'b0, sqy_reg};
            p3_ctx_reg <= c3_next;
            diff_reg   <= diff_next;
            den_reg    <= den_next;
            p4_ctx_reg <= p3_ctx_reg;
            numx_reg   <= p3_ctx_reg.ux * diff_reg;
            numy_reg   <= p3_ctx_reg.uy * diff_reg;
            den4_reg   <= den_reg;
            p5_ctx_reg <= dv_ctx;
            mx_reg     <= dv_ctx.xneg ? (32'sd0 - {1'b0, dv_qx}) : {1'b0, dv_qx};
            my_reg     <= dv_ctx.yneg ? (32'sd0 - {1'b0, dv_qy}) : {1'b0, dv_qy};
        end
    end

    col_sqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (p2_vld_reg),
        .rad   (rad_reg),
        .cin   (p2_ctx_reg),
        .vout  (sq_vld),
        .root  (sq_root),
        .cout  (sq_ctx)
    );

    col_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .en    (en),
        .vin   (p4_vld_reg),
        .num_x (numx_reg),
        .num_y (numy_reg),
        .den   (den4_reg),
        .cin   (p4_ctx_reg),
        .vout  (dv_vld),
        .qx    (dv_qx),
        .qy    (dv_qy),
        .cout  (dv_ctx)
    );

    always_comb
    begin
        sa_x = sat_sum({p5_ctx_reg.ax[31], p5_ctx_reg.ax} + {mx_reg[31], mx_reg});
        sa_y = sat_sum({p5_ctx_reg.ay[31], p5_ctx_reg.ay} + {my_reg[31], my_reg});
        sb_x = sat_sum({p5_ctx_reg.bx[31], p5_ctx_reg.bx} - {mx_reg[31], mx_reg});
        sb_y = sat_sum({p5_ctx_reg.by[31], p5_ctx_reg.by} - {my_reg[31], my_reg});
        hit  = 1'b0;
        res_next.nax    = p5_ctx_reg.ax;
        res_next.nay    = p5_ctx_reg.ay;
        res_next.nbx    = p5_ctx_reg.bx;
        res_next.nby    = p5_ctx_reg.by;
        res_next.fax    = 32'sd0;
        res_next.fay    = 32'sd0;
        res_next.fbx    = 32'sd0;
        res_next.fby    = 32'sd0;
        res_next.status = ST_APART;
        case (p5_ctx_reg.kind)
            K_COIN:
            begin
                res_next.status = ST_COIN;
            end
            K_CONTACT:
            begin
                if (!p5_ctx_reg.afix)
                begin
                    res_next.nax = sa_x[31:0];
                    res_next.nay = sa_y[31:0];
                    res_next.fax = mx_reg;
                    res_next.fay = my_reg;
                    hit = sa_x[32] | sa_y[32];
                end
                if (!p5_ctx_reg.bfix)
                begin
                    res_next.nbx = sb_x[31:0];
                    res_next.nby = sb_y[31:0];
                    res_next.fbx = 32'sd0 - mx_reg;
                    res_next.fby = 32'sd0 - my_reg;
                    hit = hit | sb_x[32] | sb_y[32];
                end
                res_next.status = hit ? ST_SAT : ST_CONTACT;
            end
            default:
            begin
                res_next.status = ST_APART;
            end
        endcase
    end

    // output register plus skid entry; park a word in the skid when stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_vld_reg  <= 1'b0;
            sk_full_reg <= 1'b0;
        end
        else if (!en)
        begin
            if (out_ready)
                sk_full_reg <= 1'b0;
        end
        else if (p5_vld_reg)
        begin
            if (ov_vld_reg && !out_ready)
                sk_full_reg <= 1'b1;
            else
                ov_vld_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            ov_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!en)
        begin
            if (out_ready)
                ov_reg <= sk_reg;
        end
        else if (p5_vld_reg)
        begin
            if (ov_vld_reg && !out_ready)
                sk_reg <= res_next;
            else
                ov_reg <= res_next;
        end
    end

    assign out_valid = ov_vld_reg;
    assign new_a_x   = ov_reg.nax;
    assign new_a_y   = ov_reg.nay;
    assign new_b_x   = ov_reg.nbx;
    assign new_b_y   = ov_reg.nby;
    assign force_a_x = ov_reg.fax;
    assign force_a_y = ov_reg.fay;
    assign force_b_x = ov_reg.fbx;
    assign force_b_y = ov_reg.fby;
    assign status    = ov_reg.status;

endmodule

// ===== rtl/core/col_checker.sv =====
// ----------------------------------------------------------------------------
// col_checker
// Port-level checks on the circle overlap resolver, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module col_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic signed [31:0] new_a_x,
    input logic signed [31:0] force_a_x,
    input logic signed [31:0] force_a_y,
    input logic signed [31:0] force_b_x,
    input logic signed [31:0] force_b_y,
    input logic [1:0]         status
);
    import col_pkg::*;

    // a stalled word holds
    `CHK_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(new_a_x))

    // no displacement unless contact was resolved
    `CHK_NOW(a_no_force, out_valid && (status == ST_APART || status == ST_COIN), force_a_x == 32'sd0 && force_a_y == 32'sd0 && force_b_x == 32'sd0 && force_b_y == 32'sd0)

    // equal and opposite push when both circles move
    `CHK_NOW(a_opposite, out_valid && (status == ST_CONTACT || status == ST_SAT) && force_a_x != 32'sd0 && force_b_x != 32'sd0, force_b_x == 32'sd0 - force_a_x)

    // an empty output register never blocks the input
    `CHK_NEXT(a_skid_room, !out_valid, in_ready)

endmodule

bind circle_overlap_resolver_top col_checker u_col_checker (.*);
